### rtl/sfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_pkg
// Types and constants shared by the status frame parser modules.
// ----------------------------------------------------------------------------
package sfp_pkg;

	localparam logic [7:0] HDR_BYTE  = 8'hBB;
	localparam logic [7:0] LEN_BYTE  = 8'h0B;
	localparam logic [7:0] DIR_BYTE  = 8'h05;
	localparam logic [7:0] PRES_MASK = 8'h80;

	localparam int         STORE_DEPTH   = 6;
	localparam logic [3:0] FIRST_PAYLOAD = 4'd4;
	localparam logic [3:0] CHECK_POS     = 4'd10;

	typedef enum logic [4:0] {
		ST_HEAD = 5'b00001,
		ST_ADDR = 5'b00010,
		ST_LEN  = 5'b00100,
		ST_DIR  = 5'b01000,
		ST_DATA = 5'b10000
	} parse_state_t;

	// Checked frame: raw bytes as received, pressure reduced to one masked bit
	typedef struct packed {
		logic [7:0] command;
		logic [7:0] volt_lo;
		logic [7:0] volt_hi;
		logic [7:0] curr_lo;
		logic [7:0] curr_hi;
		logic       pressure;
	} frame_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

### rtl/sfp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_front
// Byte-serial header hunt, payload capture and running checksum. Emits one
// frame record per frame whose checksum matches.
// ----------------------------------------------------------------------------
module sfp_front import sfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_addr,
	input  logic       byte_valid,
	input  logic [7:0] rx_byte,
	output logic       rec_valid,
	output frame_rec_t rec
);

	parse_state_t state_q;
	logic [3:0]   pos_q;
	logic [7:0]   sum_q;
	logic [7:0]   dev_addr_q;
	logic [7:0]   payload_q [STORE_DEPTH];
	logic [2:0]   store_idx;
	logic [7:0]   sum_next;

	assign store_idx = 3'(pos_q - FIRST_PAYLOAD);
	assign sum_next  = sum_q + rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= 8'h00;
		end else if (cfg_we) begin
			dev_addr_q <= cfg_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HEAD;
			pos_q   <= 4'd0;
			sum_q   <= 8'h00;
		end else if (byte_valid) begin
			unique case (state_q)
				ST_HEAD: begin
					if (rx_byte == HDR_BYTE) begin
						sum_q   <= rx_byte;
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					if (rx_byte == dev_addr_q) begin
						sum_q   <= sum_next;
						state_q <= ST_LEN;
					end else begin
						state_q <= ST_HEAD;
					end
				end
				ST_LEN: begin
					if (rx_byte == LEN_BYTE) begin
						sum_q   <= sum_next;
						state_q <= ST_DIR;
					end else begin
						state_q <= ST_HEAD;
					end
				end
				ST_DIR: begin
					if (rx_byte == DIR_BYTE) begin
						sum_q   <= sum_next;
						pos_q   <= FIRST_PAYLOAD;
						state_q <= ST_DATA;
					end else begin
						state_q <= ST_HEAD;
					end
				end
				ST_DATA: begin
					if (pos_q < CHECK_POS) begin
						sum_q <= sum_next;
						pos_q <= pos_q + 4'd1;
					end else begin
						pos_q   <= 4'd0;
						state_q <= ST_HEAD;
					end
				end
				default: begin
					state_q <= ST_HEAD;
				end
			endcase
		end
	end

	// Payload bytes 4..9 land in the store; no reset needed
	always_ff @(posedge clk) begin
		if (byte_valid && state_q == ST_DATA && pos_q < CHECK_POS) begin
			payload_q[store_idx] <= rx_byte;
		end
	end

	assign rec_valid = byte_valid && state_q == ST_DATA && pos_q >= CHECK_POS
	                   && sum_q == rx_byte;

	always_comb begin
		rec.command  = payload_q[0];
		rec.volt_lo  = payload_q[1];
		rec.volt_hi  = payload_q[2];
		rec.curr_lo  = payload_q[3];
		rec.curr_hi  = payload_q[4];
		rec.pressure = |(payload_q[5] & PRES_MASK);
	end

endmodule

### rtl/sfp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_queue
// Short register queue of frame records between the parser and the output.
// ----------------------------------------------------------------------------
module sfp_queue import sfp_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  frame_rec_t    wr_data,
	input  logic          rd_en,
	output frame_rec_t    rd_data,
	output queue_status_t status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST   = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_MX = CW'(DEPTH);

	frame_rec_t    entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign status.full  = (count_q == CNT_MX);
	assign status.empty = (count_q == '0);
	assign do_wr        = wr_en && !status.full;
	assign do_rd        = rd_en && !status.empty;
	assign rd_data      = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

### rtl/sfp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_back
// Assembles result fields from a frame record and holds them in the output
// register until the receiver pops them.
// ----------------------------------------------------------------------------
module sfp_back import sfp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  queue_status_t      q_status,
	input  frame_rec_t         q_data,
	output logic               q_pop,
	output logic               empty,
	input  logic               pop,
	output logic        [7:0]  command_echo,
	output logic        [15:0] voltage_mv,
	output logic signed [15:0] current_ma,
	output logic               pressure_flag
);

	logic               valid_q;
	logic        [7:0]  command_q;
	logic        [15:0] voltage_q;
	logic signed [15:0] current_q;
	logic               pressure_q;

	// Refill when the output register is free or is being drained
	assign q_pop = !q_status.empty && (!valid_q || pop);
	assign empty = !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			command_q  <= q_data.command;
			voltage_q  <= {q_data.volt_hi, q_data.volt_lo};
			current_q  <= signed'({q_data.curr_hi, q_data.curr_lo});
			pressure_q <= q_data.pressure;
		end
	end

	assign command_echo  = command_q;
	assign voltage_mv    = voltage_q;
	assign current_ma    = current_q;
	assign pressure_flag = pressure_q;

endmodule

### rtl/status_frame_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_frame_parser_unit
// Hunts a received byte stream for 11-byte status replies and reports the
// fields of each reply whose checksum matches.
// ----------------------------------------------------------------------------
// Input: one byte per transaction, taken when push is high and full is low.
// One byte can be taken every cycle while full is low; full rises only while
// the record queue between parser and output holds QUEUE_DEPTH frames not yet drained.
// Output: while empty is low the oldest result is on command_echo,
// voltage_mv, current_ma and pressure_flag; pop takes it. The edge that takes
// the checksum byte of a frame enqueues its record, which then moves into the
// output register once that register is free or is being popped. Frames
// with a bad checksum or a bad header byte produce nothing.
// Configuration: the device address is written through cfg_valid and
// device_address; cfg_ready is always high. Write it only while idle.
// Reset: arst_n clears the parser to header hunting, empties the queue and
// the output register, and sets the device address to zero.
// Stall: while pop stays low the output holds and the queue fills; once it
// is full, full holds off new bytes.
// ----------------------------------------------------------------------------
module status_frame_parser_unit import sfp_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [7:0]  device_address,
	input  logic               push,
	output logic               full,
	input  logic        [7:0]  rx_byte,
	output logic               empty,
	input  logic               pop,
	output logic        [7:0]  command_echo,
	output logic        [15:0] voltage_mv,
	output logic signed [15:0] current_ma,
	output logic               pressure_flag
);

	logic          byte_take;
	logic          rec_valid;
	frame_rec_t    rec;
	frame_rec_t    q_data;
	queue_status_t q_status;
	logic          q_pop;

	assign cfg_ready = 1'b1;
	assign full      = q_status.full;
	assign byte_take = push && !full;

	sfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid),
		.cfg_addr   (device_address),
		.byte_valid (byte_take),
		.rx_byte    (rx_byte),
		.rec_valid  (rec_valid),
		.rec        (rec)
	);

	sfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_valid),
		.wr_data (rec),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.status  (q_status)
	);

	sfp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_status      (q_status),
		.q_data        (q_data),
		.q_pop         (q_pop),
		.empty         (empty),
		.pop           (pop),
		.command_echo  (command_echo),
		.voltage_mv    (voltage_mv),
		.current_ma    (current_ma),
		.pressure_flag (pressure_flag)
	);

	// A good frame record is only produced for a taken byte, never into a full queue
	a_rec_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid |-> (byte_take && !q_status.full))
		else $error("frame record produced without queue room");

	// A queued record reaches an idle output register on the next edge
	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_status.empty && empty) |=> !empty)
		else $error("output register not refilled from queue");

	// Output register is drained only by a pop
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result lost without pop");

	// The queue is never drained while the output register is occupied and held
	a_hold_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |-> !q_pop)
		else $error("queue read while output stalled");

endmodule
